// ===== hdl/stt_pkg.sv =====
// shared types and constants for the sine test-tone generator
// no dependencies
`default_nettype none

package stt_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int AMP_BITS    = 15;
  localparam int FRAMES_BITS = 17;
  localparam int VOL_BITS    = 7;
  localparam int FREQ_BITS   = 16;
  localparam int DUR_BITS    = 16;
  localparam int FREQ_C_BITS = 12;
  localparam int DUR_C_BITS  = 13;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [FREQ_BITS-1:0]   FREQ_MIN    = 16'd100;
  localparam logic [FREQ_BITS-1:0]   FREQ_MAX    = 16'd3000;
  localparam logic [DUR_BITS-1:0]    DUR_MIN     = 16'd100;
  localparam logic [DUR_BITS-1:0]    DUR_MAX     = 16'd5000;
  localparam logic [VOL_BITS-1:0]    VOL_RESET   = 7'd35;
  localparam logic [VOL_BITS-1:0]    VOL_MAX     = 7'd100;
  localparam logic [15:0]            AMP_PER_PCT = 16'd260;
  localparam logic [FRAMES_BITS-1:0] FRAMES_MAX  = 17'd131071;

  typedef struct packed {
    logic                 cmd;
    logic [FREQ_BITS-1:0] tone_freq;
    logic [DUR_BITS-1:0]  tone_len;
  } req_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          tone_active;
    logic                          last_frame;
  } rsp_word_t;

  typedef struct packed {
    logic                valid;
    logic                tone;
    logic                active;
    logic                last;
    logic [AMP_BITS-1:0] amp;
  } frame_t;

endpackage

`default_nettype wire

// ===== hdl/stt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module stt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stt_sine_fill.sv =====
// loads the full-wave sine table into the ram after reset, one entry a cycle
// quarter-wave values come from a constant table built at elaboration
`default_nettype none

module stt_sine_fill #(
  parameter int SINE_INDEX_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  output      logic                       busy,
  output      logic                       we,
  output      logic [SINE_INDEX_BITS-1:0] waddr,
  output      logic [15:0]                wdata
);

  localparam int QBITS   = SINE_INDEX_BITS - 2;
  localparam int QUARTER = 1 << QBITS;
  localparam logic [SINE_INDEX_BITS-1:0] LAST_ADDR = '1;

  function automatic logic [15:0] quarter_sine(input int r, input int qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] one;
    one = 64'd1 << 30;
    x  = (64'(r) * 64'd1686629713) >> qbits;
    x2 = (x * x) >> 30;
    t  = one - x2 / 64'd110;
    t  = one - ((x2 * t) >> 30) / 64'd72;
    t  = one - ((x2 * t) >> 30) / 64'd42;
    t  = one - ((x2 * t) >> 30) / 64'd20;
    t  = one - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    s  = (s * 64'd32767 + (one >> 1)) >> 30;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[15:0];
  endfunction

  logic [15:0] qtab [QUARTER+1];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_qtab
    localparam logic [15:0] QV = quarter_sine(g, QBITS);
    assign qtab[g] = QV;
  end

  logic [SINE_INDEX_BITS-1:0] cnt;
  logic [SINE_INDEX_BITS-1:0] cnt_next;
  logic                       busy_next;
  logic [1:0]                 quad;
  logic [QBITS:0]             rem;
  logic [QBITS:0]             qidx;
  logic [15:0]                qval;

  always_comb begin
    quad = cnt[SINE_INDEX_BITS-1 -: 2];
    rem  = {1'b0, cnt[QBITS-1:0]};
    qidx = quad[0] ? ((QBITS+1)'(QUARTER) - rem) : rem;
    qval = qtab[qidx];
    wdata = quad[1] ? (16'd0 - qval) : qval;
    we    = busy;
    waddr = cnt;
    cnt_next  = cnt + 1'b1;
    busy_next = busy && (cnt != LAST_ADDR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      busy <= busy_next;
      cnt  <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stt_phase.sv =====
// tone state: volume, phase accumulator, step, frame count and amplitude
// issues the sine table read and holds the frame stage; uses stt_pkg
`default_nettype none

module stt_phase #(
  parameter int SAMPLE_RATE     = 16000,
  parameter int SINE_INDEX_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire stt_pkg::req_word_t            req,
  input  wire logic                          cfg_we,
  input  wire logic [stt_pkg::VOL_BITS-1:0]  cfg_data,
  input  wire logic                          hold,
  output      logic [SINE_INDEX_BITS-1:0]    rd_addr,
  output      stt_pkg::frame_t               frame
);

  import stt_pkg::*;

  localparam int STEP_SHIFT = 28;
  localparam int STEP_MW    = PHASE_BITS + 16;
  localparam int STEP_PW    = FREQ_C_BITS + STEP_MW;
  localparam logic [63:0] STEP_NUM = 64'd1 << (PHASE_BITS + STEP_SHIFT);
  localparam logic [STEP_MW-1:0] STEP_MUL =
    STEP_MW'((STEP_NUM + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE));

  localparam int FRM_SHIFT = 23;
  localparam int FRM_MW    = 29;
  localparam int FRM_PW    = DUR_C_BITS + FRM_MW;
  localparam int FRM_RW    = FRM_PW - FRM_SHIFT;
  localparam logic [63:0] FRM_NUM = 64'(SAMPLE_RATE) << FRM_SHIFT;
  localparam logic [FRM_MW-1:0] FRM_MUL = FRM_MW'((FRM_NUM + 64'd999) / 64'd1000);

  logic [VOL_BITS-1:0]    volume;
  logic [PHASE_BITS-1:0]  phase_acc;
  logic [PHASE_BITS-1:0]  phase_step;
  logic [FRAMES_BITS-1:0] frames_left;
  logic [AMP_BITS-1:0]    tone_amplitude;

  logic [FREQ_C_BITS-1:0] freq_c;
  logic [DUR_C_BITS-1:0]  dur_c;
  logic [STEP_PW-1:0]     step_prod;
  logic [FRM_PW-1:0]      frm_prod;
  logic [FRM_RW-1:0]      frm_raw;
  logic [FRAMES_BITS-1:0] frames_start;
  logic [AMP_BITS-1:0]    amp_start;
  logic                   running;
  logic                   is_start;
  logic                   is_tick;
  frame_t                 frame_next;

  always_comb begin
    if (req.tone_freq < FREQ_MIN) begin
      freq_c = FREQ_C_BITS'(FREQ_MIN);
    end else if (req.tone_freq > FREQ_MAX) begin
      freq_c = FREQ_C_BITS'(FREQ_MAX);
    end else begin
      freq_c = req.tone_freq[FREQ_C_BITS-1:0];
    end
    if (req.tone_len < DUR_MIN) begin
      dur_c = DUR_C_BITS'(DUR_MIN);
    end else if (req.tone_len > DUR_MAX) begin
      dur_c = DUR_C_BITS'(DUR_MAX);
    end else begin
      dur_c = req.tone_len[DUR_C_BITS-1:0];
    end
    step_prod = STEP_PW'(freq_c) * STEP_PW'(STEP_MUL);
    frm_prod  = FRM_PW'(dur_c) * FRM_PW'(FRM_MUL);
    frm_raw   = frm_prod[FRM_PW-1:FRM_SHIFT];
    frames_start = (frm_raw > FRM_RW'(FRAMES_MAX)) ? FRAMES_MAX : FRAMES_BITS'(frm_raw);
    amp_start = AMP_BITS'(16'(volume) * AMP_PER_PCT);
  end

  always_comb begin
    running  = (frames_left != '0);
    is_start = accept && (req.cmd == CMD_START);
    is_tick  = accept && (req.cmd == CMD_TICK) && running;
    rd_addr  = phase_acc[PHASE_BITS-1 -: SINE_INDEX_BITS];
    frame_next.valid  = accept;
    frame_next.amp    = tone_amplitude;
    frame_next.tone   = 1'b0;
    frame_next.active = 1'b0;
    frame_next.last   = 1'b0;
    if (req.cmd == CMD_START) begin
      frame_next.active = (frames_start != '0);
    end else if (running) begin
      frame_next.tone   = 1'b1;
      frame_next.active = (frames_left != FRAMES_BITS'(1));
      frame_next.last   = (frames_left == FRAMES_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume         <= VOL_RESET;
      phase_acc      <= '0;
      phase_step     <= '0;
      frames_left    <= '0;
      tone_amplitude <= '0;
    end else begin
      if (cfg_we) begin
        volume <= (cfg_data > VOL_MAX) ? VOL_MAX : cfg_data;
      end
      if (is_start) begin
        phase_acc      <= '0;
        phase_step     <= step_prod[STEP_SHIFT +: PHASE_BITS];
        frames_left    <= frames_start;
        tone_amplitude <= amp_start;
      end else if (is_tick) begin
        phase_acc   <= phase_acc + phase_step;
        frames_left <= frames_left - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (!hold) begin
      frame.valid <= frame_next.valid;
    end
    if (!hold && accept) begin
      frame.tone   <= frame_next.tone;
      frame.active <= frame_next.active;
      frame.last   <= frame_next.last;
      frame.amp    <= frame_next.amp;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stt_scale.sv =====
// scales the sine table word by the tone amplitude and holds the output word
// uses stt_pkg
`default_nettype none

module stt_scale (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire stt_pkg::frame_t                   frame,
  input  wire logic [stt_pkg::SAMPLE_BITS-1:0]   rom_data,
  output      logic                              hold,
  output      logic                              rsp_valid,
  input  wire logic                              rsp_stall,
  output      stt_pkg::rsp_word_t                rsp
);

  import stt_pkg::*;

  logic                          load;
  logic                          neg;
  logic [SAMPLE_BITS-1:0]        mag_w;
  logic [AMP_BITS-1:0]           mag;
  logic [2*AMP_BITS-1:0]         prod;
  logic [SAMPLE_BITS-1:0]        scaled;
  logic signed [SAMPLE_BITS-1:0] sample;

  always_comb begin
    load = frame.valid && (!rsp_valid || !rsp_stall);
    hold = frame.valid && !load;
    neg    = rom_data[SAMPLE_BITS-1];
    mag_w  = neg ? (SAMPLE_BITS'(0) - rom_data) : rom_data;
    mag    = mag_w[AMP_BITS-1:0];
    prod   = (2*AMP_BITS)'(mag) * (2*AMP_BITS)'(frame.amp);
    scaled = SAMPLE_BITS'(prod[2*AMP_BITS-1:AMP_BITS]);
    if (!frame.tone) begin
      sample = '0;
    end else if (neg) begin
      sample = SAMPLE_BITS'(0) - scaled;
    end else begin
      sample = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.left_sample  <= sample;
      rsp.right_sample <= sample;
      rsp.tone_active  <= frame.active;
      rsp.last_frame   <= frame.last;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sine_test_tone_generator_core.sv =====
// sine test-tone generator top level
// uses stt_pkg, stt_ram, stt_sine_fill, stt_phase, stt_scale
//
// req channel: one word per item. cmd start loads a tone (frequency clamped
// to 100..3000 Hz, duration to 100..5000 ms, amplitude from volume); cmd
// tick asks for one stereo frame. every word gives exactly one rsp word.
// a start word answers with zero samples and tone_active set; a tick with
// no tone left answers with zeros.
// cfg_we / cfg_data write the volume in percent, saturated to 100; it is
// taken up at the next start.
// a word goes into the frame stage and ram read, then into the rsp word.
// throughput: one word per cycle while req_stall is low; the phase add
// and ram read at the accepting edge, the 15x15 multiply a stage after it.
// reset: req_stall stays high for 2^SINE_INDEX_BITS cycles while the sine
// table is written into the ram, one entry a cycle; volume resets to 35.
// when rsp_stall is high the output word holds, one more word waits in
// the frame stage, and req_stall rises only once both are full.
`default_nettype none

module sine_test_tone_generator_core #(
  parameter int SAMPLE_RATE     = 16000,
  parameter int SINE_INDEX_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output      logic                          req_stall,
  input  wire stt_pkg::req_word_t            req,
  output      logic                          rsp_valid,
  input  wire logic                          rsp_stall,
  output      stt_pkg::rsp_word_t            rsp,
  input  wire logic                          cfg_we,
  input  wire logic [stt_pkg::VOL_BITS-1:0]  cfg_data
);

  import stt_pkg::*;

  localparam int ROM_DEPTH = 1 << SINE_INDEX_BITS;

  logic                       fill_busy;
  logic                       fill_we;
  logic [SINE_INDEX_BITS-1:0] fill_addr;
  logic [SAMPLE_BITS-1:0]     fill_data;
  logic [SINE_INDEX_BITS-1:0] rd_addr;
  logic [SAMPLE_BITS-1:0]     rom_data;
  logic                       hold;
  logic                       accept;
  frame_t                     frame;

  assign req_stall = fill_busy || hold;
  assign accept    = req_valid && !req_stall;

  stt_sine_fill #(
    .SINE_INDEX_BITS(SINE_INDEX_BITS)
  ) u_fill (
    .clk  (clk),
    .rst  (rst),
    .busy (fill_busy),
    .we   (fill_we),
    .waddr(fill_addr),
    .wdata(fill_data)
  );

  stt_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(ROM_DEPTH)
  ) u_sine_ram (
    .clk  (clk),
    .we   (fill_we),
    .waddr(fill_addr),
    .wdata(fill_data),
    .re   (accept),
    .raddr(rd_addr),
    .rdata(rom_data)
  );

  stt_phase #(
    .SAMPLE_RATE    (SAMPLE_RATE),
    .SINE_INDEX_BITS(SINE_INDEX_BITS),
    .PHASE_BITS     (PHASE_BITS)
  ) u_phase (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .req     (req),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .hold    (hold),
    .rd_addr (rd_addr),
    .frame   (frame)
  );

  stt_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .frame    (frame),
    .rom_data (rom_data),
    .hold     (hold),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire
